/* hdl/pulse_height_histogrammer_top_macros.svh */
// ----------------------------------------------------------------------------
// pulse height histogrammer assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PULSE_HEIGHT_HISTOGRAMMER_TOP_MACROS_SVH
`define PULSE_HEIGHT_HISTOGRAMMER_TOP_MACROS_SVH

// property holds on every clock edge
`define PHH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// when cond holds, expr holds in the next cycle
`define PHH_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

/* hdl/phh_pkg.sv */
// ----------------------------------------------------------------------------
// phh_pkg
// shared widths, codes and result type of the pulse height histogrammer
// ----------------------------------------------------------------------------
package phh_pkg;

	localparam int SMPL_W     = 12;
	localparam int WIN_W      = 16;
	localparam int OUT_CNT_W  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [SMPL_W-1:0] TRIG_RESET = 12'd15;
	localparam logic [WIN_W-1:0]  WIN_RESET  = 16'd1024;

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;
	localparam int OQ_LIMIT = OQ_DEPTH - 1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic {
		KIND_PULSE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER = 1'b0,
		REG_WINDOW  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		kind_t                 kind;
		logic [SMPL_W-1:0]     bin_index;
		logic [OUT_CNT_W-1:0]  bin_count;
	} phh_result_t;

endpackage

/* hdl/phh_in_if.sv */
// ----------------------------------------------------------------------------
// phh_in_if
// request channel: adc samples and bin read requests
// ----------------------------------------------------------------------------
interface phh_in_if;
	import phh_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SMPL_W-1:0] sample;
	logic [SMPL_W-1:0] bin_select;

	modport source (output valid, output opcode, output sample, output bin_select,
		input ready);
	modport sink (input valid, input opcode, input sample, input bin_select,
		output ready);

endinterface

/* hdl/phh_out_if.sv */
// ----------------------------------------------------------------------------
// phh_out_if
// response channel: pulse events and bin read answers
// ----------------------------------------------------------------------------
interface phh_out_if;
	import phh_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [SMPL_W-1:0]    bin_index;
	logic [OUT_CNT_W-1:0] bin_count;

	modport source (output valid, output kind, output bin_index, output bin_count,
		input ready);
	modport sink (input valid, input kind, input bin_index, input bin_count,
		output ready);

endinterface

/* hdl/phh_out_fifo.sv */
// ----------------------------------------------------------------------------
// phh_out_fifo
// small result queue in front of the response channel
// ----------------------------------------------------------------------------
module phh_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  phh_pkg::phh_result_t              push_data,
	output logic [phh_pkg::OQ_CNT_W-1:0]      count,
	phh_out_if.source                         rsp
);
	import phh_pkg::*;

	phh_result_t           entries_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic                  pop;
	phh_result_t           head;

	assign pop   = rsp.valid && rsp.ready;
	assign head  = entries_q[rd_ptr_q];
	assign count = count_q;

	assign rsp.valid     = (count_q != '0);
	assign rsp.kind      = head.kind;
	assign rsp.bin_index = head.bin_index;
	assign rsp.bin_count = head.bin_count;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

endmodule

/* hdl/pulse_height_histogrammer_top.sv */
// ----------------------------------------------------------------------------
// pulse_height_histogrammer_top
// pulse height analyzer: peak capture after a trigger, histogram of peaks
// ----------------------------------------------------------------------------
// usage
// - req channel: opcode sample feeds one adc sample, opcode read asks for the
//   count of bin_select; one item per transfer
// - rsp channel: kind pulse carries the peak of a finished capture window and
//   the bin count after its increment; kind read carries the requested bin
//   and its count (zero for a bin beyond the histogram)
// - cfg port: cfg_we writes cfg_data into trigger level or window length
//   selected by cfg_index; write only while the block is idle
// - throughput: one item per cycle while req.ready is high; the histogram is
//   one synchronous ram with one read and one write port; read-modify-write
//   of one bin in back-to-back cycles is covered by a one-entry write forward
// - result path: the ram read register, then the increment into the result
//   queue, from which the result is presented on rsp
// - reset: capture logic re-arms, registers take their defaults, then a clear
//   pass writes zero to every bin, one bin per cycle, with req.ready low;
//   cfg writes are taken during the pass
// - stall: results wait in a four-entry queue; apart from the clear pass,
//   req.ready drops only when the queue plus the item in flight could fill it
// HIST_BINS must be a power of two
// ----------------------------------------------------------------------------
`include "pulse_height_histogrammer_top_macros.svh"

module pulse_height_histogrammer_top #(
	parameter int HIST_BINS  = 4096,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [phh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [phh_pkg::CFG_DATA_W-1:0]    cfg_data,
	phh_in_if.sink                            req,
	phh_out_if.source                         rsp
);
	import phh_pkg::*;

	localparam int ABITS = $clog2(HIST_BINS);
	localparam int EXT_W = ABITS + SMPL_W;

	// configuration
	logic [SMPL_W-1:0]     trig_q;
	logic [WIN_W-1:0]      win_q;

	// capture state
	logic                  capturing_q;
	logic [WIN_W-1:0]      samples_left_q;
	logic [SMPL_W-1:0]     peak_q;

	// clear pass
	logic                  clr_active_q;
	logic [ABITS-1:0]      clr_addr_q;

	// stage 0 decode
	logic                  acc;
	logic                  is_read;
	logic                  win_end;
	logic                  trig_hit;
	logic                  ev;
	logic                  rd;
	logic                  mem_re;
	logic [SMPL_W-1:0]     peak_new;
	logic [EXT_W-1:0]      sel_ext;
	logic [EXT_W-1:0]      peak_ext;
	logic [ABITS-1:0]      sel_addr;
	logic [ABITS-1:0]      peak_addr;
	logic                  sel_in_range;
	logic [ABITS-1:0]      rd_addr;

	// stage 1
	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [SMPL_W-1:0]     index_s1;
	logic [ABITS-1:0]      addr_s1;
	logic                  inrange_s1;
	logic [COUNT_BITS-1:0] rdata_s1;
	logic [COUNT_BITS-1:0] base_cnt;
	logic [COUNT_BITS-1:0] inc_cnt;
	logic                  fwd_hit;
	logic                  s1_we;
	logic [OUT_CNT_W-1:0]  res_cnt;
	phh_result_t           res;

	// write forward
	logic                  fwd_v_q;
	logic [ABITS-1:0]      fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	// histogram ram
	logic [COUNT_BITS-1:0] hist_mem [HIST_BINS];
	logic                  mem_we;
	logic [ABITS-1:0]      mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	// output queue
	logic [OQ_CNT_W-1:0]   oq_count;
	logic [OQ_CNT_W-1:0]   oq_level;

	// accept only when not clearing and the queue keeps room for all in flight
	assign oq_level  = oq_count + OQ_CNT_W'(valid_s1);
	assign req.ready = !clr_active_q && (oq_level < OQ_CNT_W'(OQ_LIMIT));
	assign acc       = req.valid && req.ready;

	// ---------------- stage 0: capture control and ram read ----------------
	always_comb begin
		is_read  = (op_t'(req.opcode) == OP_READ);
		peak_new = (req.sample > peak_q) ? req.sample : peak_q;
		win_end  = capturing_q && (samples_left_q <= WIN_W'(1));
		trig_hit = (req.sample > trig_q) && (win_q != '0);
		ev       = acc && !is_read && win_end;
		rd       = acc && is_read;
		mem_re   = ev || rd;

		// bins are taken modulo HIST_BINS, reads above the top bin answer zero
		sel_ext                 = '0;
		sel_ext[SMPL_W-1:0]     = req.bin_select;
		peak_ext                = '0;
		peak_ext[SMPL_W-1:0]    = peak_new;
		sel_addr                = sel_ext[ABITS-1:0];
		peak_addr               = peak_ext[ABITS-1:0];
		sel_in_range            = ((sel_ext >> ABITS) == '0);
		rd_addr                 = is_read ? sel_addr : peak_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= TRIG_RESET;
			win_q  <= WIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRIGGER: trig_q <= cfg_data[SMPL_W-1:0];
				REG_WINDOW:  win_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q    <= 1'b0;
			samples_left_q <= '0;
			peak_q         <= '0;
		end else if (acc && !is_read) begin
			if (capturing_q) begin
				if (win_end) begin
					// window done, re-arm
					capturing_q    <= 1'b0;
					samples_left_q <= '0;
					peak_q         <= '0;
				end else begin
					samples_left_q <= samples_left_q - WIN_W'(1);
					peak_q         <= peak_new;
				end
			end else if (trig_hit) begin
				// triggering sample itself is not part of the window
				capturing_q    <= 1'b1;
				samples_left_q <= win_q;
				peak_q         <= '0;
			end
		end
	end

	// clear pass after reset, one bin per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ABITS'(1);
			if (clr_addr_q == ABITS'(HIST_BINS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// stage 1 pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			kind_s1    <= is_read ? KIND_READ : KIND_PULSE;
			index_s1   <= is_read ? req.bin_select : peak_new;
			addr_s1    <= rd_addr;
			inrange_s1 <= is_read ? sel_in_range : 1'b1;
		end
	end

	// ---------------- histogram ram ----------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= hist_mem[rd_addr];
		end
	end

	// ---------------- stage 1: increment, write back, result ----------------
	always_comb begin
		// bin written on the previous edge was read stale
		fwd_hit  = fwd_v_q && (fwd_addr_q == addr_s1);
		base_cnt = fwd_hit ? fwd_data_q : rdata_s1;
		inc_cnt  = base_cnt + COUNT_BITS'(1);
		s1_we    = valid_s1 && (kind_s1 == KIND_PULSE);

		mem_we    = clr_active_q || s1_we;
		mem_waddr = clr_active_q ? clr_addr_q : addr_s1;
		mem_wdata = clr_active_q ? '0 : inc_cnt;

		res_cnt = '0;
		if (kind_s1 == KIND_PULSE) begin
			res_cnt[COUNT_BITS-1:0] = inc_cnt;
		end else if (inrange_s1) begin
			res_cnt[COUNT_BITS-1:0] = base_cnt;
		end
		res.kind      = kind_s1;
		res.bin_index = index_s1;
		res.bin_count = res_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else begin
			fwd_v_q <= s1_we;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= inc_cnt;
		end
	end

	phh_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.count     (oq_count),
		.rsp       (rsp)
	);

	// ---------------- assertions ----------------
	`PHH_ASSERT(a_clear_idle, clr_active_q |-> !valid_s1, "ram access during clear pass")
	`PHH_ASSERT(a_window_live, capturing_q |-> (samples_left_q != '0), "capture with empty window")
	`PHH_ASSERT(a_s1_from_accept, valid_s1 |-> $past(req.valid && req.ready), "stage 1 without transfer")
	`PHH_ASSERT(a_queue_room, oq_level <= OQ_CNT_W'(OQ_LIMIT), "result queue overcommitted")
	`PHH_ASSERT_NEXT(a_event_rearms, ev, !capturing_q && valid_s1, "pulse end did not re-arm")

endmodule
